/* rtl/prf_pkg.sv */
// ----------------------------------------------------------------------------
// prf_pkg
// Types and constants shared by the payment request framer modules.
// ----------------------------------------------------------------------------
package prf_pkg;

  localparam int ValWidth    = 31;
  localparam int NumDigits   = 10;
  localparam int BcdWidth    = 4 * NumDigits;
  localparam int NumBcdBytes = NumDigits / 2;
  localparam int NbWidth     = $clog2(NumBcdBytes + 1);
  localparam int IdxWidth    = $clog2(NumBcdBytes);
  localparam int LenWidth    = 5;

  localparam logic [7:0] TagPrice  = 8'hB0;
  localparam logic [7:0] TagOrder  = 8'hB1;
  localparam logic [7:0] AsciiZero = 8'h30;

  // Fixed body bytes outside the BCD fields: the price tag and its count plus
  // the nine trailing bytes. The order field adds its own tag and count.
  localparam int BodyFixedLen = 11;
  localparam int NumTail      = 9;

  typedef logic [NumBcdBytes-1:0][7:0] bcd_t;

  // One converted request, handed from the front to the back.
  typedef struct packed {
    bcd_t               p_bcd;
    logic [NbWidth-1:0] p_nbytes;
    bcd_t               o_bcd;
    logic [NbWidth-1:0] o_nbytes;
    logic               o_has;
  } conv_t;

endpackage

/* rtl/prf_if.sv */
// ----------------------------------------------------------------------------
// prf_req_if / prf_frm_if
// Valid/ready channels for incoming requests and outgoing frame bytes.
// ----------------------------------------------------------------------------
interface prf_req_if;
  logic                         valid;
  logic                         ready;
  logic [prf_pkg::ValWidth-1:0] price;
  logic [prf_pkg::ValWidth-1:0] order_number;

  modport source (output valid, output price, output order_number, input ready);
  modport sink (input valid, input price, input order_number, output ready);
endinterface

interface prf_frm_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

/* rtl/payment_request_framer.sv */
// ----------------------------------------------------------------------------
// payment_request_framer
// Builds a tagged request frame with a length prefix and CRC-16/ARC trailer.
// ----------------------------------------------------------------------------
// Each accepted request yields a frame of 18 to 29 beats, one byte per cycle
// while the sink is ready, the last beat flagged by frame_end. The front
// accepts a request, converts price and order number to BCD and hands the
// result over; a two-entry queue between the front and the byte emitter lets
// the next conversion run while the current frame is still being sent.
module payment_request_framer (
  input  logic      clk_i,
  input  logic      rst_ni,
  prf_req_if.sink   req_i,
  prf_frm_if.source frm_o
);
  import prf_pkg::*;

  logic  push_valid, push_ready, pop_valid, pop_ready;
  conv_t push_data, pop_data;

  prf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  prf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  prf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .frm_o       (frm_o)
  );

endmodule

/* rtl/prf_front.sv */
// ----------------------------------------------------------------------------
// prf_front
// Accepts a request and converts price and order number to packed BCD by
// shift-and-add-three, one bit per cycle for both values at once.
// ----------------------------------------------------------------------------
module prf_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  prf_req_if.sink        req_i,
  output logic           push_valid_o,
  input  logic           push_ready_i,
  output prf_pkg::conv_t push_data_o
);
  import prf_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CONV = 3'b010,
    F_PUSH = 3'b100
  } front_state_e;

  localparam int ItWidth = $clog2(ValWidth);

  front_state_e         state_q, state_d;
  logic [ItWidth-1:0]   it_q, it_d;
  logic [ValWidth-1:0]  p_bin_q, p_bin_d, o_bin_q, o_bin_d;
  logic [BcdWidth-1:0]  p_bcd_q, p_bcd_d, o_bcd_q, o_bcd_d;
  logic                 o_has_q, o_has_d;
  logic [BcdWidth-1:0]  p_adj, o_adj;

  function automatic logic [BcdWidth-1:0] dabble_adj(input logic [BcdWidth-1:0] b);
    logic [BcdWidth-1:0] r;
    r = b;
    for (int d = 0; d < NumDigits; d++) begin
      if (r[4*d +: 4] >= 4'd5) begin
        r[4*d +: 4] = r[4*d +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  function automatic logic [NbWidth-1:0] bcd_nbytes(input logic [BcdWidth-1:0] b);
    logic [NbWidth-1:0] n;
    n = NbWidth'(1);
    for (int j = 1; j < NumBcdBytes; j++) begin
      if (b[8*j +: 8] != 8'd0) begin
        n = NbWidth'(j + 1);
      end
    end
    return n;
  endfunction

  assign p_adj = dabble_adj(p_bcd_q);
  assign o_adj = dabble_adj(o_bcd_q);

  assign req_i.ready  = (state_q == F_IDLE);
  assign push_valid_o = (state_q == F_PUSH);

  assign push_data_o.p_bcd    = bcd_t'(p_bcd_q);
  assign push_data_o.p_nbytes = bcd_nbytes(p_bcd_q);
  assign push_data_o.o_bcd    = bcd_t'(o_bcd_q);
  assign push_data_o.o_nbytes = bcd_nbytes(o_bcd_q);
  assign push_data_o.o_has    = o_has_q;

  always_comb begin
    state_d = state_q;
    it_d    = it_q;
    p_bin_d = p_bin_q;
    o_bin_d = o_bin_q;
    p_bcd_d = p_bcd_q;
    o_bcd_d = o_bcd_q;
    o_has_d = o_has_q;
    unique case (state_q)
      F_IDLE: begin
        if (req_i.valid) begin
          p_bin_d = req_i.price;
          o_bin_d = req_i.order_number;
          p_bcd_d = '0;
          o_bcd_d = '0;
          o_has_d = (req_i.order_number != '0);
          it_d    = '0;
          state_d = F_CONV;
        end
      end
      F_CONV: begin
        p_bcd_d = {p_adj[BcdWidth-2:0], p_bin_q[ValWidth-1]};
        o_bcd_d = {o_adj[BcdWidth-2:0], o_bin_q[ValWidth-1]};
        p_bin_d = {p_bin_q[ValWidth-2:0], 1'b0};
        o_bin_d = {o_bin_q[ValWidth-2:0], 1'b0};
        it_d    = it_q + ItWidth'(1);
        if (it_q == ItWidth'(ValWidth - 1)) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q    <= it_d;
    p_bin_q <= p_bin_d;
    o_bin_q <= o_bin_d;
    p_bcd_q <= p_bcd_d;
    o_bcd_q <= o_bcd_d;
    o_has_q <= o_has_d;
  end

endmodule

/* rtl/prf_queue.sv */
// ----------------------------------------------------------------------------
// prf_queue
// Two-entry queue of converted requests between the front and the back.
// ----------------------------------------------------------------------------
module prf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  prf_pkg::conv_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output prf_pkg::conv_t pop_data_o
);
  import prf_pkg::*;

  localparam int Depth = 2;

  conv_t      mem_q [Depth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign push_ready_o = (count_q != 2'(Depth));
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/prf_back.sv */
// ----------------------------------------------------------------------------
// prf_back
// Walks one converted request byte by byte: length digits, tagged body and
// CRC-16/ARC over the body, through a registered output stage.
// ----------------------------------------------------------------------------
module prf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  prf_pkg::conv_t pop_data_i,
  prf_frm_if.source      frm_o
);
  import prf_pkg::*;

  typedef enum logic [10:0] {
    B_IDLE = 11'b000_0000_0001,
    B_LEN  = 11'b000_0000_0010,
    B_PTAG = 11'b000_0000_0100,
    B_PCNT = 11'b000_0000_1000,
    B_PBCD = 11'b000_0001_0000,
    B_OTAG = 11'b000_0010_0000,
    B_OCNT = 11'b000_0100_0000,
    B_OBCD = 11'b000_1000_0000,
    B_TAIL = 11'b001_0000_0000,
    B_CRCL = 11'b010_0000_0000,
    B_CRCH = 11'b100_0000_0000
  } back_state_e;

  back_state_e   state_q, state_d;
  conv_t         ent_q;
  logic [3:0]    cnt_q, cnt_d;
  logic [1:0]    tens_q;
  logic [3:0]    units_q;
  logic [15:0]   crc_q;
  logic [7:0]    out_byte_q, byte_d;
  logic          out_end_q, out_valid_q;
  logic          step, in_body;
  logic [LenWidth-1:0] len;
  logic [1:0]    tens;
  logic [3:0]    units;

  function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [7:0] tail_byte(input logic [3:0] idx);
    logic [7:0] r;
    unique case (idx)
      4'd0:    r = 8'hA2;
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h01;
      4'd3:    r = 8'hA4;
      4'd4:    r = 8'h04;
      4'd5:    r = 8'h35;
      4'd6:    r = 8'h32;
      4'd7:    r = 8'h36;
      4'd8:    r = 8'h33;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  assign len = LenWidth'(BodyFixedLen) + LenWidth'(pop_data_i.p_nbytes)
             + (pop_data_i.o_has ? (LenWidth'(pop_data_i.o_nbytes) + LenWidth'(2))
                                 : LenWidth'(0));

  always_comb begin
    priority if (len >= LenWidth'(20)) begin
      tens  = 2'd2;
      units = 4'(len - LenWidth'(20));
    end else if (len >= LenWidth'(10)) begin
      tens  = 2'd1;
      units = 4'(len - LenWidth'(10));
    end else begin
      tens  = 2'd0;
      units = 4'(len);
    end
  end

  assign pop_ready_o = (state_q == B_IDLE);
  assign step        = (state_q != B_IDLE) && (!out_valid_q || frm_o.ready);
  assign in_body     = (state_q != B_IDLE) && (state_q != B_LEN)
                    && (state_q != B_CRCL) && (state_q != B_CRCH);

  assign frm_o.valid      = out_valid_q;
  assign frm_o.frame_byte = out_byte_q;
  assign frm_o.frame_end  = out_end_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    byte_d  = 8'd0;
    unique case (state_q)
      B_IDLE: begin
        if (pop_valid_i) begin
          state_d = B_LEN;
          cnt_d   = 4'd0;
        end
      end
      B_LEN: begin
        priority if (cnt_q == 4'd2) begin
          byte_d = AsciiZero + {6'd0, tens_q};
        end else if (cnt_q == 4'd3) begin
          byte_d = AsciiZero + {4'd0, units_q};
        end else begin
          byte_d = AsciiZero;
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd3) begin
          state_d = B_PTAG;
        end
      end
      B_PTAG: begin
        byte_d  = TagPrice;
        state_d = B_PCNT;
      end
      B_PCNT: begin
        byte_d  = 8'(ent_q.p_nbytes);
        cnt_d   = 4'(ent_q.p_nbytes) - 4'd1;
        state_d = B_PBCD;
      end
      B_PBCD: begin
        byte_d = ent_q.p_bcd[cnt_q[IdxWidth-1:0]];
        cnt_d  = cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          cnt_d   = 4'd0;
          state_d = ent_q.o_has ? B_OTAG : B_TAIL;
        end
      end
      B_OTAG: begin
        byte_d  = TagOrder;
        state_d = B_OCNT;
      end
      B_OCNT: begin
        byte_d  = 8'(ent_q.o_nbytes);
        cnt_d   = 4'(ent_q.o_nbytes) - 4'd1;
        state_d = B_OBCD;
      end
      B_OBCD: begin
        byte_d = ent_q.o_bcd[cnt_q[IdxWidth-1:0]];
        cnt_d  = cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          cnt_d   = 4'd0;
          state_d = B_TAIL;
        end
      end
      B_TAIL: begin
        byte_d = tail_byte(cnt_q);
        cnt_d  = cnt_q + 4'd1;
        if (cnt_q == 4'(NumTail - 1)) begin
          state_d = B_CRCL;
        end
      end
      B_CRCL: begin
        byte_d  = crc_q[7:0];
        state_d = B_CRCH;
      end
      B_CRCH: begin
        byte_d  = crc_q[15:8];
        state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == B_IDLE || step) begin
        state_q <= state_d;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (frm_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE) begin
      if (pop_valid_i) begin
        ent_q   <= pop_data_i;
        tens_q  <= tens;
        units_q <= units;
        crc_q   <= 16'd0;
        cnt_q   <= cnt_d;
      end
    end else if (step) begin
      cnt_q      <= cnt_d;
      out_byte_q <= byte_d;
      out_end_q  <= (state_q == B_CRCH);
      if (in_body) begin
        crc_q <= crc_update(crc_q, byte_d);
      end
    end
  end

endmodule
